/* hdl/bmp_row_integer_resize_macros.svh */
// ----------------------------------------------------------------------------
// bmp_row_integer_resize assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BMP_ROW_INTEGER_RESIZE_MACROS_SVH
`define BMP_ROW_INTEGER_RESIZE_MACROS_SVH

// property must hold at every clock edge out of reset
`define BRIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define BRIR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/brir_pkg.sv */
// ----------------------------------------------------------------------------
// brir_pkg
// Types and fixed constants of the row resizer: field widths, register
// indexes, item kinds and the command passed from front to back end.
// ----------------------------------------------------------------------------
package brir_pkg;

  localparam int RGB_W       = 24;
  localparam int COLOR_W     = 8;
  localparam int FACTOR_W    = 5;
  localparam int CNT_W       = 4;
  localparam int PAD_W       = 2;
  localparam int WIDTH_W     = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int MAX_RESULTS = 16;

  // command queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHRINK_MODE  = 2'd0,
    REG_SCALE_FACTOR = 2'd1,
    REG_IN_WIDTH     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  // one command expands into cnt_m1+1 results
  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [CNT_W-1:0] cnt_m1;
    logic             has_pixel;
    logic [PAD_W-1:0] pad;
    logic             row_end;
  } cmd_t;

endpackage

/* hdl/brir_front.sv */
// ----------------------------------------------------------------------------
// brir_front
// Accepts input items, tracks row and column position, keeps the line buffer
// and turns each item into at most one command for the back end.
// ----------------------------------------------------------------------------
`include "bmp_row_integer_resize_macros.svh"

module brir_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [brir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brir_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_kind,
  input  logic [brir_pkg::COLOR_W-1:0]       in_red,
  input  logic [brir_pkg::COLOR_W-1:0]       in_green,
  input  logic [brir_pkg::COLOR_W-1:0]       in_blue,
  input  logic [brir_pkg::QCW-1:0]           q_count,
  output logic                               q_push,
  output brir_pkg::cmd_t                     q_data
);

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int FMAX = (MAX_FACTOR < brir_pkg::MAX_RESULTS) ? MAX_FACTOR
                                                               : brir_pkg::MAX_RESULTS;

  logic                           shrink_r;
  logic [brir_pkg::FACTOR_W-1:0]  factor_r;
  logic [brir_pkg::WIDTH_W-1:0]   width_r;

  logic [WW-1:0]                  col_r, col_nxt;
  logic [brir_pkg::CNT_W-1:0]     row_r, row_nxt;
  logic [brir_pkg::CNT_W-1:0]     rep_left_r, rep_left_nxt;
  logic [WW-1:0]                  rep_col_r, rep_col_nxt;
  logic [brir_pkg::CNT_W-1:0]     rep_rep_r, rep_rep_nxt;
  logic [brir_pkg::CNT_W-1:0]     phase_r, phase_nxt;
  logic [brir_pkg::PAD_W-1:0]     kept_r, kept_nxt;

  logic                           b_valid_r;
  brir_pkg::cmd_t                 b_cmd_r;
  logic                           b_mem_r;
  logic [brir_pkg::RGB_W-1:0]     rd_r;
  logic [brir_pkg::RGB_W-1:0]     line_mem [MAX_WIDTH];

  logic [WW-1:0]                  w_eff;
  logic [brir_pkg::FACTOR_W-1:0]  f_eff;
  logic [brir_pkg::CNT_W-1:0]     fm1;
  logic [1:0]                     w_lo;
  logic [3:0]                     pad_prod;
  logic [brir_pkg::PAD_W-1:0]     enl_pad;
  logic [brir_pkg::RGB_W-1:0]     pix;
  logic                           acc;
  logic                           row_last;
  logic                           kept;
  logic [brir_pkg::PAD_W-1:0]     kept_sum;
  logic                           rep_wrap;
  logic                           col_wrap;
  logic                           emit;
  logic                           use_mem;
  logic                           mem_we;
  brir_pkg::cmd_t                 cmd;

  // clamp registers to their usable range
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (factor_r == '0) begin
      f_eff = brir_pkg::FACTOR_W'(1);
    end else if (32'(factor_r) > 32'(FMAX)) begin
      f_eff = brir_pkg::FACTOR_W'(FMAX);
    end else begin
      f_eff = factor_r;
    end
  end

  assign fm1      = brir_pkg::CNT_W'(f_eff - brir_pkg::FACTOR_W'(1));
  // row of n pixels is 3n bytes, so the padding count is n mod 4
  assign w_lo     = 2'(w_eff);
  assign pad_prod = {2'b00, w_lo} * {2'b00, f_eff[1:0]};
  assign enl_pad  = pad_prod[1:0];

  assign pix      = {in_red, in_green, in_blue};
  assign full     = ({1'b0, q_count} + {{brir_pkg::QCW{1'b0}}, b_valid_r})
                    >= (brir_pkg::QCW + 1)'(brir_pkg::QDEPTH);
  assign acc      = push && !full;

  assign row_last = ({1'b0, col_r} + (WW + 1)'(1)) >= {1'b0, w_eff};
  assign kept     = (phase_r == '0);
  assign kept_sum = kept_r + brir_pkg::PAD_W'(kept);
  assign rep_wrap = ({1'b0, rep_rep_r} + brir_pkg::FACTOR_W'(1)) >= f_eff;
  assign col_wrap = ({1'b0, rep_col_r} + (WW + 1)'(1)) >= {1'b0, w_eff};

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    rep_left_nxt = rep_left_r;
    rep_col_nxt  = rep_col_r;
    rep_rep_nxt  = rep_rep_r;
    phase_nxt    = phase_r;
    kept_nxt     = kept_r;
    emit         = 1'b0;
    use_mem      = 1'b0;
    mem_we       = 1'b0;
    cmd          = '0;
    if (acc) begin
      if (shrink_r) begin
        if (brir_pkg::kind_t'(in_kind) == brir_pkg::KIND_PIXEL) begin
          if ((row_r == '0) && kept) begin
            emit          = 1'b1;
            cmd.rgb       = pix;
            cmd.has_pixel = 1'b1;
            cmd.row_end   = row_last;
            cmd.pad       = row_last ? kept_sum : '0;
          end else if ((row_r == '0) && row_last) begin
            // kept row whose last column is dropped still closes the row
            emit        = 1'b1;
            cmd.row_end = 1'b1;
            cmd.pad     = kept_sum;
          end
          if (row_last) begin
            col_nxt   = '0;
            phase_nxt = '0;
            kept_nxt  = '0;
            row_nxt   = (({1'b0, row_r} + brir_pkg::FACTOR_W'(1)) >= f_eff)
                        ? '0 : row_r + brir_pkg::CNT_W'(1);
          end else begin
            col_nxt   = col_r + WW'(1);
            kept_nxt  = kept_sum;
            phase_nxt = (({1'b0, phase_r} + brir_pkg::FACTOR_W'(1)) >= f_eff)
                        ? '0 : phase_r + brir_pkg::CNT_W'(1);
          end
        end
      end else if (brir_pkg::kind_t'(in_kind) == brir_pkg::KIND_PIXEL) begin
        // pixels arriving during replay are dropped
        if (rep_left_r == '0) begin
          mem_we        = 1'b1;
          emit          = 1'b1;
          cmd.rgb       = pix;
          cmd.cnt_m1    = fm1;
          cmd.has_pixel = 1'b1;
          cmd.row_end   = row_last;
          cmd.pad       = row_last ? enl_pad : '0;
          if (row_last) begin
            col_nxt      = '0;
            rep_left_nxt = fm1;
            rep_col_nxt  = '0;
            rep_rep_nxt  = '0;
          end else begin
            col_nxt = col_r + WW'(1);
          end
        end
      end else if (rep_left_r != '0) begin
        emit          = 1'b1;
        use_mem       = 1'b1;
        cmd.has_pixel = 1'b1;
        if (rep_wrap) begin
          rep_rep_nxt = '0;
          if (col_wrap) begin
            rep_col_nxt  = '0;
            rep_left_nxt = rep_left_r - brir_pkg::CNT_W'(1);
            cmd.row_end  = 1'b1;
            cmd.pad      = enl_pad;
          end else begin
            rep_col_nxt = rep_col_r + WW'(1);
          end
        end else begin
          rep_rep_nxt = rep_rep_r + brir_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r   <= 1'b0;
      factor_r   <= brir_pkg::FACTOR_W'(1);
      width_r    <= brir_pkg::WIDTH_W'(1);
      col_r      <= '0;
      row_r      <= '0;
      rep_left_r <= '0;
      rep_col_r  <= '0;
      rep_rep_r  <= '0;
      phase_r    <= '0;
      kept_r     <= '0;
      b_valid_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (brir_pkg::cfg_reg_t'(cfg_index))
        brir_pkg::REG_SHRINK_MODE: begin
          shrink_r <= cfg_data[0];
        end
        brir_pkg::REG_SCALE_FACTOR: begin
          factor_r <= cfg_data[brir_pkg::FACTOR_W-1:0];
        end
        brir_pkg::REG_IN_WIDTH: begin
          width_r <= cfg_data[brir_pkg::WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
      // any listed register write starts a new raster
      if ((brir_pkg::cfg_reg_t'(cfg_index) == brir_pkg::REG_SHRINK_MODE) ||
          (brir_pkg::cfg_reg_t'(cfg_index) == brir_pkg::REG_SCALE_FACTOR) ||
          (brir_pkg::cfg_reg_t'(cfg_index) == brir_pkg::REG_IN_WIDTH)) begin
        col_r      <= '0;
        row_r      <= '0;
        rep_left_r <= '0;
        rep_col_r  <= '0;
        rep_rep_r  <= '0;
        phase_r    <= '0;
        kept_r     <= '0;
      end
      b_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      rep_left_r <= rep_left_nxt;
      rep_col_r  <= rep_col_nxt;
      rep_rep_r  <= rep_rep_nxt;
      phase_r    <= phase_nxt;
      kept_r     <= kept_nxt;
      b_valid_r  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd_r <= cmd;
    b_mem_r <= use_mem;
  end

  // line buffer, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_r[AW-1:0]] <= pix;
    end
    rd_r <= line_mem[rep_col_r[AW-1:0]];
  end

  always_comb begin
    q_data = b_cmd_r;
    if (b_mem_r) begin
      q_data.rgb = rd_r;
    end
  end

  assign q_push = b_valid_r;

  `BRIR_NEVER(a_no_replay_in_shrink, shrink_r && (rep_left_r != '0), "replay pending in shrink mode")

endmodule

/* hdl/brir_fifo.sv */
// ----------------------------------------------------------------------------
// brir_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "bmp_row_integer_resize_macros.svh"

module brir_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  brir_pkg::cmd_t            din,
  input  logic                      pop,
  output brir_pkg::cmd_t            dout,
  output logic                      empty,
  output logic [brir_pkg::QCW-1:0]  count
);

  brir_pkg::cmd_t               mem_r [brir_pkg::QDEPTH];
  logic [brir_pkg::QAW-1:0]     wr_ptr_r;
  logic [brir_pkg::QAW-1:0]     rd_ptr_r;
  logic [brir_pkg::QCW-1:0]     count_r;
  logic                         do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign dout   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + brir_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + brir_pkg::QAW'(1);
      end
      priority if (push && !do_pop) begin
        count_r <= count_r + brir_pkg::QCW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - brir_pkg::QCW'(1);
      end else begin
        count_r <= count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `BRIR_NEVER(a_fifo_overflow, push && !do_pop && (count_r == brir_pkg::QCW'(brir_pkg::QDEPTH)), "command queue overflow")

endmodule

/* hdl/brir_back.sv */
// ----------------------------------------------------------------------------
// brir_back
// Expands each queued command into its results, one per cycle while the
// consumer keeps popping, through an output register that the consumer pops.
// ----------------------------------------------------------------------------
`include "bmp_row_integer_resize_macros.svh"

module brir_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  brir_pkg::cmd_t                  q_head,
  output logic                            q_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [brir_pkg::COLOR_W-1:0]    out_red,
  output logic [brir_pkg::COLOR_W-1:0]    out_green,
  output logic [brir_pkg::COLOR_W-1:0]    out_blue,
  output logic                            out_has_pixel,
  output logic [brir_pkg::PAD_W-1:0]      out_pad_bytes,
  output logic                            out_row_end,
  output logic                            out_last
);

  logic [brir_pkg::CNT_W-1:0]  k_r;
  logic                        ov_r;
  logic [brir_pkg::RGB_W-1:0]  rgb_r;
  logic                        has_r;
  logic [brir_pkg::PAD_W-1:0]  pad_r;
  logic                        row_end_r;
  logic                        last_r;
  logic                        adv;
  logic                        last_res;

  assign last_res = (k_r == q_head.cnt_m1);
  // output register takes a new result when empty or being drained
  assign adv      = !q_empty && (!ov_r || pop);
  assign q_pop    = adv && last_res;
  assign empty    = !ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (adv) begin
        k_r <= last_res ? '0 : k_r + brir_pkg::CNT_W'(1);
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb_r     <= q_head.rgb;
      has_r     <= q_head.has_pixel;
      pad_r     <= last_res ? q_head.pad : '0;
      row_end_r <= last_res && q_head.row_end;
      last_r    <= last_res;
    end
  end

  assign out_red       = rgb_r[23:16];
  assign out_green     = rgb_r[15:8];
  assign out_blue      = rgb_r[7:0];
  assign out_has_pixel = has_r;
  assign out_pad_bytes = pad_r;
  assign out_row_end   = row_end_r;
  assign out_last      = last_r;

  `BRIR_ASSERT(a_k_in_range, !q_empty |-> (k_r <= q_head.cnt_m1), "repeat index past command count")
  `BRIR_ASSERT(a_k_restart, (adv && last_res) |=> (k_r == '0), "repeat index not cleared after command")

endmodule

/* hdl/bmp_row_integer_resize.sv */
// ----------------------------------------------------------------------------
// bmp_row_integer_resize
// Nearest-neighbor integer scaler for 24-bit RGB rows with BMP padding counts.
// ----------------------------------------------------------------------------
// An input item is taken in every cycle while the four-entry command queue
// has room; each item becomes at most one command. The back end sends one
// result per cycle while results are popped, so in enlarge mode a pixel
// yields factor results and input is held back to match; replay ticks and
// shrink-mode items run at one per cycle. An item's first result passes
// the front-end command register, the command queue and the output register.
// Listed register writes restart the raster position. The user must make
// configuration writes while the block is empty; it does not enforce this.

module bmp_row_integer_resize #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [brir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brir_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_kind,
  input  logic [brir_pkg::COLOR_W-1:0]    in_red,
  input  logic [brir_pkg::COLOR_W-1:0]    in_green,
  input  logic [brir_pkg::COLOR_W-1:0]    in_blue,
  output logic                            empty,
  input  logic                            pop,
  output logic [brir_pkg::COLOR_W-1:0]    out_red,
  output logic [brir_pkg::COLOR_W-1:0]    out_green,
  output logic [brir_pkg::COLOR_W-1:0]    out_blue,
  output logic                            out_has_pixel,
  output logic [brir_pkg::PAD_W-1:0]      out_pad_bytes,
  output logic                            out_row_end,
  output logic                            out_last
);

  logic                        q_push;
  brir_pkg::cmd_t              q_din;
  logic                        q_pop;
  brir_pkg::cmd_t              q_head;
  logic                        q_empty;
  logic [brir_pkg::QCW-1:0]    q_count;

  brir_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_kind   (in_kind),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_data    (q_din)
  );

  brir_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .count (q_count)
  );

  brir_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_has_pixel (out_has_pixel),
    .out_pad_bytes (out_pad_bytes),
    .out_row_end   (out_row_end),
    .out_last      (out_last)
  );

endmodule

/* test/bmp_row_integer_resize_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp_row_integer_resize_tb
// Drives pixel and replay tick items through the row resizer in both modes,
// predicts every scaled pixel and padding result, and checks each one as it
// is popped, under random gaps on the push and pop sides.
// ----------------------------------------------------------------------------
module bmp_row_integer_resize_tb;

  localparam int LINE_DEPTH     = 1024;
  localparam int FACTOR_CAP     = 16;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 330;
  localparam logic [brir_pkg::CFG_IDX_W-1:0] REG_UNUSED = brir_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic [brir_pkg::COLOR_W-1:0] red;
    logic [brir_pkg::COLOR_W-1:0] green;
    logic [brir_pkg::COLOR_W-1:0] blue;
    logic                         has_pixel;
    logic [brir_pkg::PAD_W-1:0]   pad_bytes;
    logic                         row_end;
    logic                         last;
  } scaled_pixel_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [brir_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [brir_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            push = 1'b0;
  logic                            full;
  logic                            in_kind = brir_pkg::KIND_PIXEL;
  logic [brir_pkg::COLOR_W-1:0]    in_red = '0;
  logic [brir_pkg::COLOR_W-1:0]    in_green = '0;
  logic [brir_pkg::COLOR_W-1:0]    in_blue = '0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic [brir_pkg::COLOR_W-1:0]    out_red;
  logic [brir_pkg::COLOR_W-1:0]    out_green;
  logic [brir_pkg::COLOR_W-1:0]    out_blue;
  logic                            out_has_pixel;
  logic [brir_pkg::PAD_W-1:0]      out_pad_bytes;
  logic                            out_row_end;
  logic                            out_last;

  // predictor copy of registers and raster position
  logic [brir_pkg::RGB_W-1:0] row_buf [LINE_DEPTH];
  bit               shrink_q = 1'b0;
  int unsigned      factor_q = 1;
  int unsigned      width_q = 1;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  int unsigned      replays_pending = 0;
  int unsigned      replay_col = 0;
  int unsigned      replay_rep = 0;

  scaled_pixel_t expected_pixels[$];
  int            mismatch_count = 0;
  int unsigned   effective_items = 0;
  int            send_quiet = 0;
  int            pop_quiet = 0;
  int            pop_hold = 0;
  int            stalled_cycles = 0;

  bmp_row_integer_resize #(
    .MAX_WIDTH (LINE_DEPTH),
    .MAX_FACTOR(FACTOR_CAP)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .empty        (empty),
    .pop          (pop),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_has_pixel(out_has_pixel),
    .out_pad_bytes(out_pad_bytes),
    .out_row_end  (out_row_end),
    .out_last     (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned eff_factor();
    if (factor_q < 1) return 1;
    if (factor_q > FACTOR_CAP) return FACTOR_CAP;
    return factor_q;
  endfunction

  function automatic int unsigned eff_width();
    if (width_q < 1) return 1;
    if (width_q > LINE_DEPTH) return LINE_DEPTH;
    return width_q;
  endfunction

  // zero bytes that bring a row of this many pixels to a multiple of four
  function automatic logic [brir_pkg::PAD_W-1:0] pad_for(int unsigned pixels);
    return brir_pkg::PAD_W'((4 - (3 * pixels) % 4) % 4);
  endfunction

  function automatic scaled_pixel_t make_pixel(logic [brir_pkg::RGB_W-1:0] rgb,
                                               logic has,
                                               logic [brir_pkg::PAD_W-1:0] pad,
                                               logic ends);
    scaled_pixel_t p;
    p.red       = rgb[23:16];
    p.green     = rgb[15:8];
    p.blue      = rgb[7:0];
    p.has_pixel = has;
    p.pad_bytes = pad;
    p.row_end   = ends;
    p.last      = 1'b0;
    return p;
  endfunction

  // updates the raster position and queues the results of one item;
  // returns 0 when the item is ignored by the block
  function automatic bit predict_item(brir_pkg::kind_t kind,
                                      logic [brir_pkg::RGB_W-1:0] rgb);
    scaled_pixel_t              res[$];
    int unsigned                f, w, k;
    bit                         row_last, ends, took;
    logic [brir_pkg::PAD_W-1:0] shrink_pad, grow_pad;
    logic [brir_pkg::RGB_W-1:0] px;
    f          = eff_factor();
    w          = eff_width();
    shrink_pad = pad_for((w + f - 1) / f);
    grow_pad   = pad_for(w * f);
    row_last   = (col_pos + 1 >= w);
    took       = 1'b1;
    if (shrink_q) begin
      if (kind == brir_pkg::KIND_TICK) begin
        took = 1'b0;
      end else begin
        if (row_pos == 0 && col_pos % f == 0)
          res.push_back(make_pixel(rgb, 1'b1, row_last ? shrink_pad : '0, row_last));
        else if (row_pos == 0 && row_last)
          // last column dropped: padding-only result closes the row
          res.push_back(make_pixel('0, 1'b0, shrink_pad, 1'b1));
        if (row_last) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= f) ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end
    end else if (kind == brir_pkg::KIND_PIXEL) begin
      if (replays_pending > 0) begin
        took = 1'b0;
      end else begin
        row_buf[col_pos] = rgb;
        for (k = 0; k < f; k++) begin
          ends = row_last && (k + 1 == f);
          res.push_back(make_pixel(rgb, 1'b1, ends ? grow_pad : '0, ends));
        end
        if (row_last) begin
          col_pos         = 0;
          replays_pending = f - 1;
          replay_col      = 0;
          replay_rep      = 0;
        end else begin
          col_pos++;
        end
      end
    end else if (replays_pending == 0) begin
      took = 1'b0;
    end else begin
      px   = row_buf[replay_col];
      ends = 1'b0;
      replay_rep++;
      if (replay_rep >= f) begin
        replay_rep = 0;
        replay_col++;
        if (replay_col >= w) begin
          replay_col = 0;
          replays_pending--;
          ends = 1'b1;
        end
      end
      res.push_back(make_pixel(px, 1'b1, ends ? grow_pad : '0, ends));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_pixels.push_back(res[i]);
    return took;
  endfunction

  // mostly no gap, some short ones, a few long, with quiet stretches
  function automatic int pick_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) quiet_left = $urandom_range(16, 64);
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return $urandom_range(1, 3);
      4: return $urandom_range(8, 40);
      default: return 0;
    endcase
  endfunction

  function automatic logic [brir_pkg::RGB_W-1:0] random_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return brir_pkg::RGB_W'($urandom);
    endcase
  endfunction

  task automatic drain_results();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [brir_pkg::CFG_IDX_W-1:0] idx,
                           logic [brir_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    push <= 1'b0;
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      brir_pkg::REG_SHRINK_MODE:  shrink_q = value[0];
      brir_pkg::REG_SCALE_FACTOR: factor_q = value[brir_pkg::FACTOR_W-1:0];
      brir_pkg::REG_IN_WIDTH:     width_q  = value;
      default:                    ;
    endcase
    // any listed register restarts the raster
    if (idx != REG_UNUSED) begin
      col_pos         = 0;
      row_pos         = 0;
      replays_pending = 0;
      replay_col      = 0;
      replay_rep      = 0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits are noise that the narrow registers must drop
  task automatic configure(int unsigned mode, int unsigned factor, int unsigned width);
    write_reg(brir_pkg::REG_SHRINK_MODE,
              brir_pkg::CFG_DATA_W'({$urandom_range(0, 1023), mode[0]}));
    write_reg(brir_pkg::REG_SCALE_FACTOR,
              brir_pkg::CFG_DATA_W'({$urandom_range(0, 63), factor[4:0]}));
    write_reg(brir_pkg::REG_IN_WIDTH, brir_pkg::CFG_DATA_W'(width));
  endtask

  task automatic send_item(brir_pkg::kind_t kind, logic [brir_pkg::RGB_W-1:0] rgb);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push     <= 1'b1;
    in_kind  <= kind;
    in_red   <= rgb[23:16];
    in_green <= rgb[15:8];
    in_blue  <= rgb[7:0];
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_item(kind, rgb)) effective_items++;
  endtask

  task automatic test_enlarge_row();
    int t;
    configure(0, 2, 3);
    send_item(brir_pkg::KIND_PIXEL, 24'hFFFFFF);
    // unlisted register index must not restart the row
    write_reg(REG_UNUSED, '1);
    send_item(brir_pkg::KIND_PIXEL, 24'h000000);
    send_item(brir_pkg::KIND_PIXEL, 24'h3CC35A);
    // pixel while replays are pending is ignored
    send_item(brir_pkg::KIND_PIXEL, 24'h777777);
    for (t = 0; t < 6; t++) send_item(brir_pkg::KIND_TICK, 24'h000000);
    // nothing left to replay
    send_item(brir_pkg::KIND_TICK, 24'hFFFFFF);
  endtask

  task automatic test_shrink_rows();
    configure(1, 2, 4);
    send_item(brir_pkg::KIND_PIXEL, 24'h000000);
    send_item(brir_pkg::KIND_PIXEL, 24'hFFFFFF);
    send_item(brir_pkg::KIND_PIXEL, 24'h0F0F0F);
    send_item(brir_pkg::KIND_PIXEL, 24'hF0F0F0);
    send_item(brir_pkg::KIND_TICK, 24'h123456);
    send_item(brir_pkg::KIND_PIXEL, 24'hA5A5A5);
    send_item(brir_pkg::KIND_PIXEL, 24'h5A5A5A);
  endtask

  task automatic test_config_limits();
    // zero factor and zero width act as one
    configure(0, 0, 0);
    send_item(brir_pkg::KIND_PIXEL, 24'hFFFFFF);
    send_item(brir_pkg::KIND_TICK, 24'h000000);
    // factor above range saturates
    configure(1, 31, 1);
    send_item(brir_pkg::KIND_PIXEL, 24'h000000);
    send_item(brir_pkg::KIND_PIXEL, 24'h123456);
    configure(0, 16, 1024);
    send_item(brir_pkg::KIND_PIXEL, 24'hA5A5A5);
  endtask

  task automatic test_random_rasters();
    int unsigned goal, mode, factor, width, f, w, rows, n_px, ticks, r, c, t;
    goal = effective_items + RANDOM_ITEMS;
    while (effective_items < goal) begin
      mode = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: factor = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        1, 2: factor = $urandom_range(5, 16);
        default: factor = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 19))
        0: begin
          case ($urandom_range(0, 2))
            0: width = 0;
            1: width = LINE_DEPTH;
            default: width = $urandom_range(LINE_DEPTH + 1, 2047);
          endcase
        end
        1, 2, 3: width = $urandom_range(7, 40);
        default: width = $urandom_range(1, 6);
      endcase
      // keep replay-heavy rasters short
      if (mode == 0 && factor > 4 && width > 2 && width <= LINE_DEPTH)
        width = $urandom_range(1, 2);
      configure(mode, factor, width);
      f    = eff_factor();
      w    = eff_width();
      rows = $urandom_range(1, 3);
      for (r = 0; r < rows; r++) begin
        n_px = (w > 64) ? $urandom_range(1, 20) : w;
        // broken row, cut short before a restart
        if ($urandom_range(0, 9) == 0) n_px = $urandom_range(1, n_px);
        for (c = 0; c < n_px && effective_items < goal; c++) begin
          if ($urandom_range(0, 15) == 0) send_item(brir_pkg::KIND_TICK, random_color());
          send_item(brir_pkg::KIND_PIXEL, random_color());
        end
        if (n_px < w || effective_items >= goal) break;
        if (mode == 0) begin
          ticks = w * f * (f - 1);
          for (t = 0; t < ticks && effective_items < goal; t++) begin
            if ($urandom_range(0, 19) == 0)
              send_item(brir_pkg::KIND_PIXEL, random_color());
            send_item(brir_pkg::KIND_TICK, random_color());
          end
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = pick_gap(pop_quiet);
    end
  end

  task automatic check_field(string name, logic [brir_pkg::COLOR_W-1:0] want_v,
                             logic [brir_pkg::COLOR_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    scaled_pixel_t want;
    if (rst_n && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $error("result popped with no item expected");
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.red, out_red);
        check_field("out_green", want.green, out_green);
        check_field("out_blue", want.blue, out_blue);
        check_field("out_has_pixel", brir_pkg::COLOR_W'(want.has_pixel),
                    brir_pkg::COLOR_W'(out_has_pixel));
        check_field("out_pad_bytes", brir_pkg::COLOR_W'(want.pad_bytes),
                    brir_pkg::COLOR_W'(out_pad_bytes));
        check_field("out_row_end", brir_pkg::COLOR_W'(want.row_end),
                    brir_pkg::COLOR_W'(out_row_end));
        check_field("out_last", brir_pkg::COLOR_W'(want.last),
                    brir_pkg::COLOR_W'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_enlarge_row();
    test_shrink_rows();
    test_config_limits();
    test_random_rasters();
    @(negedge clk);
    push <= 1'b0;
    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* bmp_row_integer_resize.f */
+incdir+hdl
hdl/brir_pkg.sv
hdl/brir_front.sv
hdl/brir_fifo.sv
hdl/brir_back.sv
hdl/bmp_row_integer_resize.sv
test/bmp_row_integer_resize_tb.sv
